// File: rtl/varint_record_deframer_assert.svh
// Assertion macros used by the deframer RTL.
`ifndef VARINT_RECORD_DEFRAMER_ASSERT_SVH
`define VARINT_RECORD_DEFRAMER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/vrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrd_pkg;

    localparam int unsigned LEN_W         = 32;
    localparam int unsigned HDR_IDX_W     = 3;
    localparam int unsigned HDR_MAX_BYTES = 5;

    localparam logic [7:0] HDR0_LEN_MASK = 8'h3F;
    localparam logic [7:0] HDR0_RM_MASK  = 8'h40;
    localparam logic [7:0] HDR_CONT_MASK = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SKIP    = 2'd2,
        PH_PAD     = 2'd3
    } phase_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] payload_byte;
        logic       record_last;
    } parse_res_t;

    typedef struct packed {
        phase_t phase;
        logic   length_zero;
    } parse_stat_t;

endpackage

`default_nettype wire

// File: rtl/vrd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module vrd_parser (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  wire  [7:0]          data_byte,
    input  wire                 block_end,
    output vrd_pkg::parse_res_t res,
    output vrd_pkg::parse_stat_t stat
);
    import vrd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [LEN_W-1:0]       length_reg, length_next;
    logic [HDR_IDX_W-1:0]   idx_reg, idx_next;
    logic                   removed_reg, removed_next;

    logic [4:0]             hdr_shift;
    logic [LEN_W-1:0]       hdr_term;
    logic [7:0]             len_bits;
    logic                   cont;

    assign cont     = (data_byte & HDR_CONT_MASK) != 8'd0;
    assign len_bits = data_byte & HDR_LEN_MASK;

    // Later header bytes land at shifts 6, 13, 20 and 27.
    always_comb
    begin
        case (idx_reg)
            3'd1:    hdr_shift = 5'd6;
            3'd2:    hdr_shift = 5'd13;
            3'd3:    hdr_shift = 5'd20;
            default: hdr_shift = 5'd27;
        endcase
    end

    assign hdr_term = {{(LEN_W-8){1'b0}}, len_bits} << hdr_shift;

    always_comb
    begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (idx_reg == '0)
                    begin
                        length_next  = {{(LEN_W-8){1'b0}}, data_byte & HDR0_LEN_MASK};
                        removed_next = (data_byte & HDR0_RM_MASK) != 8'd0;
                    end
                    else
                    begin
                        length_next = length_reg + hdr_term;
                    end
                    if (!cont)
                    begin
                        idx_next = '0;
                        if (length_next == '0)
                            phase_next = PH_PAD;
                        else if (removed_next)
                            phase_next = PH_SKIP;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    else if (idx_reg == HDR_IDX_W'(HDR_MAX_BYTES - 1))
                    begin
                        // overlong header: rest of block is padding
                        phase_next = PH_PAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (block_end)
                            phase_next = PH_PAD;
                    end
                end
                PH_PAYLOAD, PH_SKIP:
                begin
                    length_next = length_reg - 1'b1;
                    if (length_reg == LEN_W'(1))
                    begin
                        phase_next   = PH_HEADER;
                        idx_next     = '0;
                        removed_next = 1'b0;
                    end
                end
                PH_PAD:
                begin
                end
                default:
                begin
                end
            endcase
            // block end closes padding and truncated headers
            if (block_end && phase_next == PH_PAD)
            begin
                phase_next   = PH_HEADER;
                length_next  = '0;
                idx_next     = '0;
                removed_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.emit         = step && (phase_reg == PH_PAYLOAD);
        res.payload_byte = data_byte;
        res.record_last  = (length_reg == LEN_W'(1));
        stat.phase       = phase_reg;
        stat.length_zero = (length_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            length_reg  <= '0;
            idx_reg     <= '0;
            removed_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            idx_reg     <= idx_next;
            removed_reg <= removed_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/varint_record_deframer.sv
// Pipeline: an accepted byte that yields a payload byte passes the input register and
// the parser, then is loaded into the result register and presented on the output.
// Throughput: one byte per cycle unless the output stalls; the header/payload state updates in one step.
// Stalls: the input stalls only while both the input and result registers hold.
// Reset: rst_n clears both pipeline valids and returns the parser to the header
// phase with zero length, header index and removed flag.
`timescale 1ns / 1ps
`default_nettype none
`include "varint_record_deframer_assert.svh"

module varint_record_deframer (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] data_byte,
    input  wire        block_end,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] payload_byte,
    output logic       record_last
);
    import vrd_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] payload_reg;
    logic       last_reg;

    logic       s2_free;
    logic       step;
    logic       in_fire;

    parse_res_t  res;
    parse_stat_t stat;

    vrd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_byte_reg),
        .block_end (s1_end_reg),
        .res       (res),
        .stat      (stat)
    );

    assign s2_free  = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
    assign out_valid_next = res.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= block_end;
        end
        // load result only when a payload byte comes out
        if (res.emit)
        begin
            payload_reg <= res.payload_byte;
            last_reg    <= res.record_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign record_last  = last_reg;

    `VRD_ASSERT(a_stall_only_when_full, !in_ready |-> (s1_valid_reg && out_valid_reg), "input stalled while a stage is free")
    `VRD_ASSERT(a_payload_len_nonzero, (stat.phase == PH_PAYLOAD || stat.phase == PH_SKIP) |-> !stat.length_zero, "payload phase with zero length left")
    `VRD_ASSERT(a_last_ends_record, (res.emit && res.record_last) |=> (stat.phase == PH_HEADER), "last payload byte did not return to header")
    `VRD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && !s1_valid_reg), "valid after reset")

endmodule

`default_nettype wire

// File: bench/varint_record_deframer_checker.sv
`timescale 1ns / 1ps

module varint_record_deframer_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  wire  [7:0] data_byte,
    input  wire        block_end,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire  [7:0] payload_byte,
    input  wire        record_last,
    output int         fail_count,
    output int         pending,
    output int         bytes_out,
    output int         records_out,
    output int         records_skipped,
    output int         blocks_cut
);
    import vrd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } payload_beat_t;

    payload_beat_t due_payload[$];
    payload_beat_t oldest;

    // Parser state as seen from the input stream
    phase_t      ph;
    logic [31:0] len_acc;
    logic [2:0]  hdr_idx;
    logic        rm_flag;

    task automatic flag_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic restart_header();
        ph      = PH_HEADER;
        len_acc = '0;
        hdr_idx = '0;
        rm_flag = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic e);
        int sh;
        payload_beat_t beat;
        case (ph)
            PH_HEADER:
            begin
                if (hdr_idx == 0)
                begin
                    len_acc = {24'd0, b & HDR0_LEN_MASK};
                    rm_flag = (b & HDR0_RM_MASK) != 0;
                end
                else
                begin
                    sh = 6 + 7 * (int'(hdr_idx) - 1);
                    if (sh > 27)
                        sh = 27;
                    // keep 32 bits; anything shifted past bit 31 is lost
                    len_acc = len_acc + ({24'd0, b & HDR_LEN_MASK} << sh);
                end
                if ((b & HDR_CONT_MASK) == 0)
                begin
                    hdr_idx = '0;
                    if (len_acc == 0)
                        ph = PH_PAD;
                    else
                        ph = rm_flag ? PH_SKIP : PH_PAYLOAD;
                end
                else if (int'(hdr_idx) + 1 >= HDR_MAX_BYTES)
                    ph = PH_PAD;
                else
                begin
                    hdr_idx = hdr_idx + 1'b1;
                    if (e)
                        ph = PH_PAD;
                end
            end
            PH_PAYLOAD:
            begin
                len_acc = len_acc - 1;
                beat.data = b;
                beat.last = (len_acc == 0);
                due_payload.insert(due_payload.size(), beat);
                if (len_acc == 0)
                    restart_header();
            end
            PH_SKIP:
            begin
                len_acc = len_acc - 1;
                if (len_acc == 0)
                begin
                    records_skipped++;
                    restart_header();
                end
            end
            default:
                ;
        endcase
        // a block end closes padding and truncated headers
        if (e && ph == PH_PAD)
        begin
            blocks_cut++;
            restart_header();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restart_header();
            due_payload.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                parse_byte(data_byte, block_end);
            if (out_valid && out_ready)
            begin
                if (due_payload.size() == 0)
                    flag_error($sformatf("unexpected payload byte %02h last=%0b",
                                         payload_byte, record_last));
                else
                begin
                    oldest = due_payload.pop_front();
                    if (payload_byte !== oldest.data)
                        flag_error($sformatf("payload_byte %02h, want %02h",
                                             payload_byte, oldest.data));
                    if (record_last !== oldest.last)
                        flag_error($sformatf("record_last %0b, want %0b (byte %02h)",
                                             record_last, oldest.last, oldest.data));
                    bytes_out++;
                    if (oldest.last)
                        records_out++;
                end
            end
        end
        pending = due_payload.size();
    end

endmodule

// File: bench/varint_record_deframer_tb.sv
`timescale 1ns / 1ps

module varint_record_deframer_tb;

    localparam int IDLE_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       block_end = 1'b0;
    logic       out_ready = 1'b0;
    wire        in_ready;
    wire        out_valid;
    wire  [7:0] payload_byte;
    wire        record_last;

    int fail_count;
    int pending;
    int bytes_out;
    int records_out;
    int records_skipped;
    int blocks_cut;

    int items_sent = 0;
    int burst_left = 0;
    int blk_pos = 0;
    int blk_len = 8;
    int idle_cycles = 0;

    // {block_end, byte}: plain, removed, five-byte header with dropped high bits,
    // header closing a block, payload across a block end, zero length,
    // truncated header, overlong header, zero length on a block end
    logic [8:0] directed_seq [25] = '{
        9'h001, 9'h0FF, 9'h042, 9'h000, 9'h055,
        9'h081, 9'h080, 9'h080, 9'h080, 9'h060, 9'h1A5,
        9'h103, 9'h010, 9'h120, 9'h030,
        9'h000, 9'h1EE,
        9'h181,
        9'h080, 9'h080, 9'h080, 9'h080, 9'h080, 9'h17F,
        9'h100
    };

    logic [7:0] ready_pattern = 8'hFF;
    int         ready_mode = 0;
    int         mode_left = 0;

    always #2 clk = ~clk;

    varint_record_deframer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .block_end   (block_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .payload_byte(payload_byte),
        .record_last (record_last)
    );

    varint_record_deframer_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .record_last    (record_last),
        .fail_count     (fail_count),
        .pending        (pending),
        .bytes_out      (bytes_out),
        .records_out    (records_out),
        .records_skipped(records_skipped),
        .blocks_cut     (blocks_cut)
    );

    // Receiver: always ready, random stalls, or a rotating stall pattern
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode    <= $urandom_range(0, 2);
            mode_left     <= $urandom_range(20, 120);
            ready_pattern <= 8'($urandom) | 8'h01;
            out_ready     <= 1'b1;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (ready_mode)
                0:
                    out_ready <= 1'b1;
                1:
                    out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    out_ready     <= ready_pattern[0];
                    ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                         IDLE_LIMIT, pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
        end
        in_valid  = 1'b1;
        data_byte = b;
        block_end = e;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_block_byte(input logic [7:0] b);
        logic e;
        e = (blk_pos == blk_len - 1);
        send_byte(b, e);
        if (e)
        begin
            blk_pos = 0;
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(8, 40);
        end
        else
            blk_pos++;
    endtask

    // Zero-length header, then filler to the end of the block
    task automatic pad_block();
        int r;
        r = blk_len - blk_pos;
        send_block_byte($urandom_range(0, 1) ? 8'h00 : 8'h40);
        repeat (r - 1) send_block_byte(8'($urandom));
    endtask

    task automatic overlong_header();
        if (blk_len - blk_pos < 6)
            pad_block();
        else
        begin
            repeat (5) send_block_byte(8'($urandom) | 8'h80);
            while (blk_pos != 0)
                send_block_byte(8'($urandom));
        end
    endtask

    task automatic send_record();
        int          roll;
        int          n;
        int          nmin;
        int          r;
        logic [31:0] lv;
        logic        rm;
        logic [7:0]  hdr [5];
        roll = $urandom_range(0, 99);
        if (roll < 10)
            lv = $urandom_range(65, 200);
        else if (roll < 30)
            lv = $urandom_range(17, 64);
        else
            lv = $urandom_range(1, 16);
        rm   = ($urandom_range(0, 3) == 0);
        nmin = (lv < 64) ? 1 : 2;
        // non-minimal encodings reach the deeper header bytes
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(nmin, 5) : nmin;
        hdr[0] = {n > 1, rm, lv[5:0]};
        for (int i = 1; i < n; i++)
        begin
            if (i < 4)
                hdr[i] = {i < n - 1, 7'(lv >> (6 + 7 * (i - 1)))};
            else
                hdr[i] = {1'b0, 2'($urandom), lv[31:27]};
        end
        if (blk_len - blk_pos < n && $urandom_range(0, 9) == 0)
        begin
            // cut the header at the block end and drop the record
            r = blk_len - blk_pos;
            for (int i = 0; i < r; i++)
                send_block_byte(hdr[i]);
            return;
        end
        while (blk_len - blk_pos < n)
            pad_block();
        for (int i = 0; i < n; i++)
            send_block_byte(hdr[i]);
        repeat (lv) send_block_byte(8'($urandom));
    endtask

    initial
    begin
        int roll;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_seq[k])
            send_byte(directed_seq[k][7:0], directed_seq[k][8]);

        blk_pos = 0;
        blk_len = $urandom_range(8, 40);
        while (items_sent < 1150)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                overlong_header();
            else if (roll < 10)
                pad_block();
            else
                send_record();
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes: directed header and padding cases, then random blocks",
                 items_sent);
        $display("Got %0d payload bytes in %0d records; %0d removed skipped, %0d blocks cut",
                 bytes_out, records_out, records_skipped, blocks_cut);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
